FILE: hdl/at_response_receiver_defines.svh
// assertion macros for the response receiver
`ifndef AT_RESPONSE_RECEIVER_DEFINES_SVH
`define AT_RESPONSE_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ATR_ASSERT_IMPL(label, clock, rst_n, cond, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed");
`define ATR_ASSERT_NEXT(label, clock, rst_n, cond, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ATR_ASSERT_IMPL(label, clock, rst_n, cond, prop)
`define ATR_ASSERT_NEXT(label, clock, rst_n, cond, prop)
`endif

`endif

FILE: hdl/atr_pkg.sv
`timescale 1ns / 1ps

package atr_pkg;

	localparam int BUFFER_DEPTH = 4096;
	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int LEN_W = 13;
	localparam int TAIL_LEN = 7;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_ERROR = 2'd1,
		RES_FAIL  = 2'd2
	} res_t;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_K  = 8'h4B;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_R  = 8'h52;

endpackage

FILE: hdl/atr_cmd_if.sv
`timescale 1ns / 1ps

interface atr_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  rx_byte;
	logic [15:0] timeout_ticks;
	logic [11:0] read_index;

	modport source (output valid, command, rx_byte, timeout_ticks, read_index, input ready);
	modport sink (input valid, command, rx_byte, timeout_ticks, read_index, output ready);
endinterface

FILE: hdl/atr_res_if.sv
`timescale 1ns / 1ps

interface atr_res_if import atr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             busy_res;
	logic [1:0]       result_code;
	logic [LEN_W-1:0] length;
	logic [7:0]       read_byte;

	modport source (output valid, busy_res, result_code, length, read_byte, input ready);
	modport sink (input valid, busy_res, result_code, length, read_byte, output ready);
endinterface

FILE: hdl/atr_ram.sv
`timescale 1ns / 1ps

module atr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/at_response_receiver.sv
`timescale 1ns / 1ps
// Response receiver for a modem command channel.
// cmd channel (valid/ready): one item per command code: start (loads the tick
// timeout, clears the count and arms unless the timeout is zero), received
// byte, one millisecond tick, and buffer read.
// res channel (valid/ready): exactly one item per cmd item, in order, showing
// busy, outcome (ok, error, fail), captured length and, for reads, the byte.
// Res valid rises in the cycle after cmd acceptance. Throughput is one item
// per cycle while res is ready, set by the single write and single read port
// of the capture buffer RAM and the one output register.
// The capture buffer holds BUFFER_DEPTH bytes and is not cleared; a read of a
// never-written entry returns whatever the RAM holds.
// Reset (arst_n low) disarms the receiver, sets the outcome to fail, clears
// the count, tail bytes and timeout counter, and empties the output register.
// When res is stalled the result stays in the output register and cmd ready
// drops; no item is lost or duplicated.
`include "at_response_receiver_defines.svh"

module at_response_receiver import atr_pkg::*; (
	input logic clk,
	input logic arst_n,
	atr_cmd_if.sink cmd,
	atr_res_if.source res
);

	logic [CNT_W-1:0] count_q, count_n;
	logic             armed_q, armed_n;
	res_t             outcome_q, outcome_n;
	logic [7:0]       recent_q [TAIL_LEN];
	logic [7:0]       recent_n [TAIL_LEN];
	logic [15:0]      wait_q, wait_n;

	logic             valid_s1;
	logic             busy_s1;
	res_t             code_s1;
	logic [LEN_W-1:0] len_s1;
	logic             rd_s1;

	logic             accept;
	logic             ram_we;
	logic             ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic             rd_hit;
	logic [31:0]      idx_ext;
	logic [31:0]      cnt_ext;
	logic [CNT_W-1:0] cnt_inc;

	assign cmd.ready = !valid_s1 || res.ready;
	assign accept = cmd.valid && cmd.ready;

	assign idx_ext = 32'(cmd.read_index);
	assign ram_raddr = idx_ext[ADDR_W-1:0];
	assign cnt_inc = count_q + CNT_W'(1);

	always_comb begin
		count_n = count_q;
		armed_n = armed_q;
		outcome_n = outcome_q;
		recent_n = recent_q;
		wait_n = wait_q;
		ram_we = 1'b0;
		rd_hit = 1'b0;
		case (cmd_t'(cmd.command))
			CMD_START: begin
				count_n = '0;
				outcome_n = RES_FAIL;
				for (int i = 0; i < TAIL_LEN; i++) begin
					recent_n[i] = 8'h00;
				end
				wait_n = cmd.timeout_ticks;
				armed_n = (cmd.timeout_ticks != 16'd0);
			end
			CMD_BYTE: begin
				if (armed_q) begin
					if (count_q >= CNT_W'(BUFFER_DEPTH)) begin
						outcome_n = RES_FAIL;
						armed_n = 1'b0;
					end else begin
						ram_we = 1'b1;
						count_n = cnt_inc;
						recent_n[0] = cmd.rx_byte;
						for (int i = 1; i < TAIL_LEN; i++) begin
							recent_n[i] = recent_q[i-1];
						end
						// recent_q[0] is the byte just before this one
						if (cmd.rx_byte == CH_LF && cnt_inc >= CNT_W'(2)
								&& recent_q[0] == CH_CR) begin
							if (cnt_inc >= CNT_W'(4) && recent_q[2] == CH_O
									&& recent_q[1] == CH_K) begin
								outcome_n = RES_OK;
								armed_n = 1'b0;
							end else if (cnt_inc >= CNT_W'(7) && recent_q[5] == CH_E
									&& recent_q[4] == CH_R && recent_q[3] == CH_R
									&& recent_q[2] == CH_O && recent_q[1] == CH_R) begin
								outcome_n = RES_ERROR;
								armed_n = 1'b0;
							end
						end
					end
				end
			end
			CMD_TICK: begin
				if (armed_q) begin
					if (wait_q != 16'd0) begin
						wait_n = wait_q - 16'd1;
					end
					if (wait_q <= 16'd1) begin
						armed_n = 1'b0;
					end
				end
			end
			CMD_READ: begin
				rd_hit = (idx_ext < 32'(BUFFER_DEPTH));
			end
			default: begin
				rd_hit = 1'b0;
			end
		endcase
	end

	assign ram_re = accept && rd_hit;
	assign cnt_ext = 32'(count_n);

	atr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH),
		.AW(ADDR_W)
	) u_buf (
		.clk(clk),
		.we(accept && ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(cmd.rx_byte),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			armed_q <= 1'b0;
			outcome_q <= RES_FAIL;
			for (int i = 0; i < TAIL_LEN; i++) begin
				recent_q[i] <= 8'h00;
			end
			wait_q <= 16'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_n;
				armed_q <= armed_n;
				outcome_q <= outcome_n;
				recent_q <= recent_n;
				wait_q <= wait_n;
				valid_s1 <= 1'b1;
			end else if (res.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			busy_s1 <= armed_n;
			code_s1 <= outcome_n;
			len_s1 <= cnt_ext[LEN_W-1:0];
			rd_s1 <= rd_hit;
		end
	end

	assign res.valid = valid_s1;
	assign res.busy_res = busy_s1;
	assign res.result_code = code_s1;
	assign res.length = len_s1;
	assign res.read_byte = rd_s1 ? ram_rdata : 8'h00;

	`ATR_ASSERT_IMPL(a_armed_has_time, clk, arst_n, armed_q, wait_q != 16'd0)
	`ATR_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(BUFFER_DEPTH))
	`ATR_ASSERT_IMPL(a_final_disarms, clk, arst_n, outcome_q != RES_FAIL, !armed_q)
	`ATR_ASSERT_NEXT(a_accept_gives_res, clk, arst_n, accept, valid_s1)

endmodule

FILE: tb/tb_at_response_receiver.sv
`timescale 1ns / 1ps

module tb_at_response_receiver;
	import atr_pkg::*;

	localparam int STALL_CYCLES = 200;
	localparam int ITEMS_PER_PHASE = 500;

	typedef struct {
		logic             busy;
		res_t             code;
		logic [LEN_W-1:0] len;
		logic [7:0]       rdata;
	} reply_t;

	// tracks the receiver state and holds one expected reply per accepted item
	class reply_scoreboard;
		logic [7:0]  mem [BUFFER_DEPTH];
		int unsigned hwm;
		int unsigned count;
		bit          armed;
		res_t        outcome;
		logic [7:0]  recent [TAIL_LEN];
		logic [15:0] wait_cnt;
		reply_t      replies_due [$];
		int          errors;
		int          effective;
		int          accepted;
		int          checked;
		int          n_ok;
		int          n_err;
		int          n_timeout;
		int          n_overflow;

		function new();
			hwm = 0;
			count = 0;
			armed = 0;
			outcome = RES_FAIL;
			recent = '{default: 8'h00};
			wait_cnt = 16'h0000;
			errors = 0;
			effective = 0;
			accepted = 0;
			checked = 0;
			n_ok = 0;
			n_err = 0;
			n_timeout = 0;
			n_overflow = 0;
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		// k = 1 is the newest stored byte
		function logic [7:0] tail(int k);
			return recent[TAIL_LEN - k];
		endfunction

		function void take_byte(logic [7:0] b);
			if (!armed)
				return;
			if (count >= BUFFER_DEPTH) begin
				outcome = RES_FAIL;
				armed = 0;
				n_overflow++;
				return;
			end
			mem[count] = b;
			count++;
			if (count > hwm)
				hwm = count;
			for (int i = 0; i < TAIL_LEN - 1; i++)
				recent[i] = recent[i + 1];
			recent[TAIL_LEN - 1] = b;
			if (b != CH_LF || count < 2 || tail(2) != CH_CR)
				return;
			if (count >= 4 && tail(4) == CH_O && tail(3) == CH_K) begin
				outcome = RES_OK;
				armed = 0;
				n_ok++;
			end else if (count >= 7 && tail(7) == CH_E && tail(6) == CH_R && tail(5) == CH_R
					&& tail(4) == CH_O && tail(3) == CH_R) begin
				outcome = RES_ERROR;
				armed = 0;
				n_err++;
			end
		endfunction

		function void note_command(cmd_t c, logic [7:0] b, logic [15:0] to, logic [11:0] idx);
			reply_t r;
			logic [7:0] rd;
			rd = 8'h00;
			accepted++;
			if (!((c == CMD_BYTE || c == CMD_TICK) && !armed))
				effective++;
			case (c)
				CMD_START: begin
					count = 0;
					outcome = RES_FAIL;
					recent = '{default: 8'h00};
					wait_cnt = to;
					armed = (to != 16'h0000);
				end
				CMD_BYTE: begin
					take_byte(b);
				end
				CMD_TICK: begin
					if (armed) begin
						if (wait_cnt != 16'h0000)
							wait_cnt--;
						if (wait_cnt == 16'h0000) begin
							armed = 0;
							n_timeout++;
						end
					end
				end
				default: begin
					if (idx < BUFFER_DEPTH)
						rd = mem[idx];
				end
			endcase
			r.busy = armed;
			r.code = outcome;
			r.len = count[LEN_W-1:0];
			r.rdata = rd;
			replies_due.push_back(r);
		endfunction

		task check_reply(logic busy, logic [1:0] code, logic [LEN_W-1:0] len,
				logic [7:0] rd);
			reply_t w;
			if (replies_due.size() == 0) begin
				report("unexpected result", {14'h0, code}, 16'h0);
				return;
			end
			w = replies_due.pop_front();
			checked++;
			if (busy !== w.busy)
				report("busy_res", {15'h0, busy}, {15'h0, w.busy});
			if (code !== w.code)
				report("result_code", {14'h0, code}, {14'h0, w.code});
			if (len !== w.len)
				report("length", {{(16-LEN_W){1'b0}}, len}, {{(16-LEN_W){1'b0}}, w.len});
			if (rd !== w.rdata)
				report("read_byte", {8'h0, rd}, {8'h0, w.rdata});
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	bit   stall_req;

	reply_scoreboard sb;

	atr_cmd_if cmd_ch ();
	atr_res_if res_ch ();

	at_response_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	string near_miss [7] = '{"OK\n", "OK\r", "\r\n", "O K\r\n", "EROR\r\n", "ERRO\r\n",
		"ERROR\n"};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("timeout waiting for the receiver");
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.note_command(cmd_t'(cmd_ch.command), cmd_ch.rx_byte, cmd_ch.timeout_ticks,
				cmd_ch.read_index);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_reply(res_ch.busy_res, res_ch.result_code, res_ch.length,
				res_ch.read_byte);
	end

	// result side, with one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 0;
				res_ch.ready <= 1'b0;
				for (int n = 0; n < STALL_CYCLES; n++)
					@(posedge clk);
			end
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_item(cmd_t c, logic [7:0] b, logic [15:0] to, logic [11:0] idx);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.rx_byte <= b;
		cmd_ch.timeout_ticks <= to;
		cmd_ch.read_index <= idx;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic put_start(logic [15:0] to);
		send_item(CMD_START, 8'($urandom), to, 12'($urandom));
	endtask

	task automatic put_byte(logic [7:0] b);
		send_item(CMD_BYTE, b, 16'($urandom), 12'($urandom));
	endtask

	task automatic put_tick();
		send_item(CMD_TICK, 8'($urandom), 16'($urandom), 12'($urandom));
	endtask

	// only entries that have been written are ever read
	task automatic put_read();
		if (sb.hwm == 0)
			put_tick();
		else
			send_item(CMD_READ, 8'($urandom), 16'($urandom), 12'($urandom_range(sb.hwm - 1)));
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_body_char();
		int pick;
		string specials;
		specials = "OKER\r\n";
		pick = $urandom_range(99);
		if (pick < 40)
			put_byte(specials[$urandom_range(5)]);
		else if (pick < 50)
			put_tick();
		else if (pick < 60)
			put_read();
		else
			put_byte(8'($urandom));
	endtask

	// one command reply: start, body, an ending of some kind or none, then trailing body items
	task automatic run_reply();
		int pick;
		int n;
		logic [15:0] to;
		pick = $urandom_range(15);
		if (pick < 2)
			to = 16'h0000;
		else if (pick < 6)
			to = 16'($urandom_range(1, 4));
		else if (pick < 7)
			to = 16'($urandom);
		else
			to = 16'($urandom_range(5, 60));
		put_start(to);
		n = $urandom_range(12);
		for (int i = 0; i < n; i++)
			put_body_char();
		case ($urandom_range(4))
			0: put_text("OK\r\n");
			1: put_text("ERROR\r\n");
			2: put_text(near_miss[$urandom_range(6)]);
			3: begin
				n = (to > 40) ? 40 : int'(to);
				for (int i = 0; i < n; i++)
					put_tick();
			end
			default: ;
		endcase
		n = $urandom_range(3);
		for (int i = 0; i < n; i++)
			put_body_char();
	endtask

	task automatic put_noise();
		send_item(cmd_t'($urandom_range(3)), 8'($urandom), 16'($urandom),
			12'($urandom_range(sb.hwm == 0 ? 0 : sb.hwm - 1)));
	endtask

	task automatic run_random(int target);
		int goal;
		goal = sb.effective + target;
		while (sb.effective < goal) begin
			if ($urandom_range(99) < 15)
				put_noise();
			else
				run_reply();
		end
	endtask

	initial begin
		logic [7:0] b;
		sb = new();
		stall_req = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_START;
		cmd_ch.rx_byte <= 8'h00;
		cmd_ch.timeout_ticks <= 16'h0000;
		cmd_ch.read_index <= 12'h000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 26;
		sink_idle_pct = 84;

		// directed: ignored items while disarmed, zero timeout, shortest replies,
		// timeout by ticks, and reads of the captured bytes
		put_tick();
		put_byte(8'hFF);
		put_start(16'h0000);
		put_byte(8'h00);
		put_start(16'd4);
		put_text("OK\r\n");
		put_byte(8'hFF);
		send_item(CMD_READ, 8'h00, 16'h0000, 12'd0);
		send_item(CMD_READ, 8'hFF, 16'hFFFF, 12'd3);
		put_start(16'hFFFF);
		put_text("ERROR\r\n");
		send_item(CMD_READ, 8'h00, 16'h0000, 12'd6);
		put_start(16'd1);
		put_tick();
		put_tick();
		put_start(16'd3);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_tick();
		put_tick();
		put_tick();
		put_byte(8'h41);

		// fill the whole buffer, then one byte more overflows
		src_idle_pct = 0;
		sink_idle_pct = 0;
		put_start(16'hFFFF);
		for (int i = 0; i < BUFFER_DEPTH; i++) begin
			b = 8'($urandom_range(254));
			if (b >= CH_LF)
				b = b + 8'd1;
			put_byte(b);
		end
		put_byte(CH_LF);
		send_item(CMD_READ, 8'h00, 16'h0000, 12'd0);
		send_item(CMD_READ, 8'h00, 16'h0000, 12'hFFF);

		src_idle_pct = 26;
		sink_idle_pct = 84;
		run_random(ITEMS_PER_PHASE);

		src_idle_pct = 84;
		sink_idle_pct = 26;
		run_random(ITEMS_PER_PHASE);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_req = 1;
		run_random(ITEMS_PER_PHASE);

		cmd_ch.valid <= 1'b0;
		while (sb.replies_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d items accepted, %0d results checked, %0d mismatches",
			sb.accepted, sb.checked, sb.errors);
		$display("replies ended ok %0d, error %0d, by timeout %0d, by overflow %0d",
			sb.n_ok, sb.n_err, sb.n_timeout, sb.n_overflow);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/atr_pkg.sv
hdl/atr_cmd_if.sv
hdl/atr_res_if.sv
hdl/atr_ram.sv
hdl/at_response_receiver.sv
tb/tb_at_response_receiver.sv
